// ===== hw/rtl/complete_fragment_group_finder_macros.svh =====
// Assertion macros shared by the group finder RTL.
// Depends on nothing; files that assert pull it in with an include.
`ifndef COMPLETE_FRAGMENT_GROUP_FINDER_MACROS_SVH
`define COMPLETE_FRAGMENT_GROUP_FINDER_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define CFGF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define CFGF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/cfgf_pkg.sv =====
// Shared types and constants of the complete fragment group finder.
// Used by the controller, the datapath and the top level; depends on nothing.
package cfgf_pkg;

   localparam int SLOTS = 16;
   localparam int ID_W  = 8;
   localparam int VAL_W = 8;
   localparam int KEY_W = 16;
   localparam int CNT_W = 5;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // A key of 255 stands for id 0 restricted to entries of value 0.
   localparam logic [KEY_W-1:0] KEY_ZERO_ONLY = 16'h00ff;

   typedef struct packed {
      logic write;      // load one table entry from the request
      logic load;       // capture a query key and clear the struck set
      logic step_quad;  // register matches and the partial maxima
      logic step_best;  // register the highest matching value
      logic step_group; // register members, representative and part summary
      logic strike;     // remove the current group from the search
      logic rsp_found;  // load the result registers with the group
      logic rsp_none;   // load the result registers with zeros
   } cfgf_cmd_type;

   typedef struct packed {
      logic any_match;
      logic complete;
   } cfgf_status_type;

endpackage

// ===== hw/rtl/cfgf_ctrl.sv =====
// Controller of the group finder: sequences the search rounds.
// Depends on cfgf_pkg for the command and status structs.
module cfgf_ctrl
   import cfgf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            req_opcode,
   input  cfgf_status_type status,
   output cfgf_cmd_type    cmd,
   output logic            busy,
   output logic            rsp_valid
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MAX1  = 3'd1;
   localparam logic [2:0] ST_MAX2  = 3'd2;
   localparam logic [2:0] ST_GROUP = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_opcode == OP_QUERY) begin
                  cmd.load = 1'b1;
                  state_in = ST_MAX1;
               end else begin
                  cmd.write    = 1'b1;
                  cmd.rsp_none = 1'b1;
               end
            end
         end
         ST_MAX1: begin
            cmd.step_quad = 1'b1;
            state_in      = ST_MAX2;
         end
         ST_MAX2: begin
            cmd.step_best = 1'b1;
            state_in      = ST_GROUP;
         end
         ST_GROUP: begin
            if (status.any_match) begin
               cmd.step_group = 1'b1;
               state_in       = ST_CHECK;
            end else begin
               cmd.rsp_none = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (status.complete) begin
               cmd.rsp_found = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.strike = 1'b1;
               state_in   = ST_MAX1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_found | cmd.rsp_none;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/cfgf_dpath.sv =====
// Datapath of the group finder: entry table, match and maximum logic,
// group summary, completeness check and result registers. Uses cfgf_pkg.
module cfgf_dpath
   import cfgf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cfgf_cmd_type       cmd,
   input  logic [3:0]         req_entry_index,
   input  logic [ID_W-1:0]    req_entry_id,
   input  logic [VAL_W-1:0]   req_entry_value,
   input  logic [7:0]         req_entry_meta,
   input  logic [KEY_W-1:0]   req_query_key,
   output cfgf_status_type    status,
   output logic               rsp_found,
   output logic [3:0]         rsp_group_index,
   output logic [SLOTS-1:0]   rsp_member_mask
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   function automatic logic [VAL_W-1:0] vmax(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   // Bits 0..last set: the parts that a complete group must cover.
   function automatic logic [SLOTS-1:0] fill_mask(input logic [3:0] last);
      logic [SLOTS-1:0] m;
      for (int p = 0; p < SLOTS; p++) begin
         m[p] = (4'(p) <= last);
      end
      return m;
   endfunction

   logic [ID_W-1:0]  id_ff   [TABLE_ENTRIES];
   logic [VAL_W-1:0] val_ff  [TABLE_ENTRIES];
   logic [7:0]       meta_ff [TABLE_ENTRIES];

   logic [ID_W-1:0]  key_ff;
   logic             key_ok_ff;
   logic             zero_only_ff;
   logic [SLOTS-1:0] struck_ff;

   logic [SLOTS-1:0] match_ff;
   logic [VAL_W-1:0] quad_ff [4];
   logic [VAL_W-1:0] best_ff;
   logic             any_ff;
   logic [SLOTS-1:0] members_ff;
   logic [3:0]       rep_ff;
   logic [3:0]       last_ff;
   logic [SLOTS-1:0] parts_ff;
   logic [CNT_W-1:0] count_ff;

   logic             found_ff;
   logic [3:0]       index_ff;
   logic [SLOTS-1:0] mask_ff;

   logic [VAL_W-1:0] val_pad  [SLOTS];
   logic [7:0]       meta_pad [SLOTS];
   logic [SLOTS-1:0] match_in;
   logic [VAL_W-1:0] mval     [SLOTS];
   logic [VAL_W-1:0] quad_in  [4];
   logic [SLOTS-1:0] members_in;
   logic [SLOTS-1:0] first_in;
   logic [3:0]       rep_in;
   logic [3:0]       last_in;
   logic [SLOTS-1:0] parts_in;
   logic [CNT_W-1:0] count_in;
   logic             wr_ok;
   logic [IDX_W-1:0] wr_idx;

   assign wr_ok  = ({1'b0, req_entry_index} < 5'(TABLE_ENTRIES));
   assign wr_idx = req_entry_index[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < TABLE_ENTRIES; s++) begin
            id_ff[s]   <= '0;
            val_ff[s]  <= '0;
            meta_ff[s] <= '0;
         end
      end else if (cmd.write && wr_ok) begin
         id_ff[wr_idx]   <= req_entry_id;
         val_ff[wr_idx]  <= req_entry_value;
         meta_ff[wr_idx] <= req_entry_meta;
      end
   end

   // Slots above the table size read as empty and never match.
   genvar g;
   for (g = 0; g < SLOTS; g++) begin : g_slot
      if (g < TABLE_ENTRIES) begin : g_live
         assign val_pad[g]  = val_ff[g];
         assign meta_pad[g] = meta_ff[g];
         assign match_in[g] = key_ok_ff && !struck_ff[g] && (id_ff[g] == key_ff)
                              && (!zero_only_ff || (val_ff[g] == '0));
      end else begin : g_pad
         assign val_pad[g]  = '0;
         assign meta_pad[g] = '0;
         assign match_in[g] = 1'b0;
      end
      assign mval[g] = match_in[g] ? val_pad[g] : '0;
   end

   always_comb begin
      for (int q = 0; q < 4; q++) begin
         quad_in[q] = vmax(vmax(mval[4*q], mval[4*q+1]), vmax(mval[4*q+2], mval[4*q+3]));
      end
   end

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         members_in[s] = match_ff[s] && (val_pad[s] == best_ff);
      end
      // Isolate the lowest member: it is the representative.
      first_in = members_in & (~members_in + 1'b1);
      rep_in   = '0;
      last_in  = '0;
      parts_in = '0;
      count_in = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (first_in[s]) begin
            rep_in  = rep_in | 4'(s);
            last_in = last_in | meta_pad[s][3:0];
         end
         if (members_in[s]) begin
            parts_in = parts_in | (SLOTS'(1) << meta_pad[s][7:4]);
         end
         count_in = count_in + CNT_W'(members_in[s]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         key_ok_ff    <= 1'b0;
         zero_only_ff <= 1'b0;
         struck_ff    <= '0;
      end else if (cmd.load) begin
         key_ff       <= (req_query_key == KEY_ZERO_ONLY) ? '0 : req_query_key[ID_W-1:0];
         key_ok_ff    <= (req_query_key[KEY_W-1:ID_W] == '0);
         zero_only_ff <= (req_query_key == KEY_ZERO_ONLY);
         struck_ff    <= '0;
      end else if (cmd.strike) begin
         struck_ff <= struck_ff | members_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step_quad) begin
         match_ff <= match_in;
         quad_ff  <= quad_in;
      end
      if (cmd.step_best) begin
         best_ff <= vmax(vmax(quad_ff[0], quad_ff[1]), vmax(quad_ff[2], quad_ff[3]));
         any_ff  <= |match_ff;
      end
      if (cmd.step_group) begin
         members_ff <= members_in;
         rep_ff     <= rep_in;
         last_ff    <= last_in;
         parts_ff   <= parts_in;
         count_ff   <= count_in;
      end
   end

   // Complete when the member count equals last + 1 and the parts seen are
   // exactly 0..last, so each part occurs once.
   assign status.any_match = any_ff;
   assign status.complete  = (count_ff == ({1'b0, last_ff} + 5'd1))
                             && (parts_ff == fill_mask(last_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         index_ff <= '0;
         mask_ff  <= '0;
      end else if (cmd.rsp_found) begin
         found_ff <= 1'b1;
         index_ff <= rep_ff;
         mask_ff  <= members_ff;
      end else if (cmd.rsp_none) begin
         found_ff <= 1'b0;
         index_ff <= '0;
         mask_ff  <= '0;
      end
   end

   assign rsp_found       = found_ff;
   assign rsp_group_index = index_ff;
   assign rsp_member_mask = mask_ff;

endmodule

// ===== hw/rtl/complete_fragment_group_finder.sv =====
// Top level of the complete fragment group finder.
// Instantiates cfgf_ctrl and cfgf_dpath; uses cfgf_pkg and the macro header.
//
//   channel   handshake            payload
//   request   start / busy         req_opcode, req_entry_index, req_entry_id,
//                                  req_entry_value, req_entry_meta, req_query_key
//   response  rsp_valid (strobe)   rsp_found, rsp_group_index, rsp_member_mask
//
// A write word is answered in the next cycle and busy stays low.
// A query runs rounds; a round that finds an incomplete group strikes it. It
// answers with that group when a round finds a complete group, and with zeros
// when a round finds no match.
// Synchronous reset clears the table and the controller. The receiver cannot
// stall: rsp_valid marks each result word for exactly one cycle.
`include "complete_fragment_group_finder_macros.svh"

module complete_fragment_group_finder
   import cfgf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic [3:0]         req_entry_index,
   input  logic [ID_W-1:0]    req_entry_id,
   input  logic [VAL_W-1:0]   req_entry_value,
   input  logic [7:0]         req_entry_meta,
   input  logic [KEY_W-1:0]   req_query_key,
   output logic               rsp_valid,
   output logic               rsp_found,
   output logic [3:0]         rsp_group_index,
   output logic [SLOTS-1:0]   rsp_member_mask
);

   cfgf_cmd_type    cmd;
   cfgf_status_type status;

   cfgf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   cfgf_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_entry_index (req_entry_index),
      .req_entry_id    (req_entry_id),
      .req_entry_value (req_entry_value),
      .req_entry_meta  (req_entry_meta),
      .req_query_key   (req_query_key),
      .status          (status),
      .rsp_found       (rsp_found),
      .rsp_group_index (rsp_group_index),
      .rsp_member_mask (rsp_member_mask)
   );

   `CFGF_ASSERT_NOW(a_rep_is_member, rsp_valid && rsp_found, rsp_member_mask[rsp_group_index], "representative is not a member of the reported group")
   `CFGF_ASSERT_NOW(a_none_is_zero, rsp_valid && !rsp_found, (rsp_group_index == '0) && (rsp_member_mask == '0), "result without a group carries nonzero payload")
   `CFGF_ASSERT_NEXT(a_write_answered, start && !busy && (req_opcode == OP_WRITE), rsp_valid && !busy, "write word not answered in the next cycle")
   `CFGF_ASSERT_NOW(a_rsp_has_cause, rsp_valid, $past(busy) || $past(start), "result word without a request being served")

endmodule
